>>> hw/rtl/set_membership_table_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the set membership table RTL.
// ---------------------------------------------------------------------------
`ifndef SET_MEMBERSHIP_TABLE_ASSERT_SVH
`define SET_MEMBERSHIP_TABLE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SMT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that holds on every clock edge outside reset.
`define SMT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define SMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/smt_pkg.sv
// ---------------------------------------------------------------------------
// smt_pkg
// Shared codes and types of the set membership table.
// ---------------------------------------------------------------------------
package smt_pkg;

  localparam int unsigned ElemW = 32;

  // Operation codes; the unused code behaves as a membership check.
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_CHECK  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Token handed from one cell to the next.
  typedef struct packed {
    logic tok;
    logic found;
  } link_t;

  // Operation broadcast to every cell while the token walks.
  typedef struct packed {
    logic [1:0]       func;
    logic [ElemW-1:0] value;
  } op_t;

endpackage

>>> hw/rtl/smt_cell.sv
// ---------------------------------------------------------------------------
// smt_cell
// One storage cell of the chain: holds one entry, compares it with the
// broadcast value when the token arrives, and shifts or loads its entry.
// ---------------------------------------------------------------------------
module smt_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  smt_pkg::op_t             op,
  input  logic [CNT_W-1:0]         count,
  input  smt_pkg::link_t           link_in,
  input  logic [smt_pkg::ElemW-1:0] next_entry,
  output smt_pkg::link_t           link_out,
  output logic [smt_pkg::ElemW-1:0] entry
);

  logic tok;
  logic found;
  logic in_use;
  logic match;
  logic hit;

  assign in_use = CNT_W'(IDX) < count;
  assign match  = in_use && (entry == op.value);
  assign hit    = found || match;

  assign link_out.tok   = tok;
  assign link_out.found = hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok   <= 1'b0;
      found <= 1'b0;
    end else begin
      tok   <= link_in.tok;
      found <= link_in.found;
    end
  end

  // Cells from the matching one up to the last used one pull their upper
  // neighbor down; the first free cell takes a new value once no match was seen.
  always_ff @(posedge clk) begin
    if (tok) begin
      if (op.func == smt_pkg::FUNC_REMOVE && hit && in_use) begin
        entry <= next_entry;
      end else if (op.func == smt_pkg::FUNC_ADD && !found && CNT_W'(IDX) == count) begin
        entry <= op.value;
      end
    end
  end

endmodule

>>> hw/rtl/set_membership_table.sv
// ---------------------------------------------------------------------------
// set_membership_table
// A set of distinct 32-bit values kept in a chain of storage cells.
// ---------------------------------------------------------------------------
// Usage:
// An operation (func, element) is transferred on a clock edge where start is
// high and busy is low. func selects add, remove or membership check; the
// unused code acts as a check. A token then walks the chain of CAPACITY
// cells, one cell per cycle, comparing, shifting entries down on a remove
// and loading the first free cell on an add.
// Exactly one result follows each operation: done rises as the token leaves the
// last cell and stays high for one cycle with status, element_echo and
// entry_count. busy stays high until that result is registered, so one
// operation runs at a time and the next one may be transferred in the cycle
// that done is shown; an operation's length is set by the token's walk
// through the chain.
// The receiver cannot stall; results are not held beyond their cycle.
// Reset empties the set (entry count zero) and clears any walk in flight;
// no clearing pass of the cells is needed.
// ---------------------------------------------------------------------------
module set_membership_table #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func,
  input  logic signed [31:0] element,
  output logic               done,
  output logic [1:0]         status,
  output logic signed [31:0] element_echo,
  output logic [7:0]         entry_count
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic                      accept;
  smt_pkg::op_t              op;
  logic [CntW-1:0]           count;
  logic [CntW-1:0]           count_next;
  logic [1:0]                status_next;
  smt_pkg::link_t            lnk [0:CAPACITY];
  logic [smt_pkg::ElemW-1:0] ent [0:CAPACITY-1];
  logic [CAPACITY-1:0]       tok_vec;
  logic                      last;
  logic                      found;
  logic                      full;
  logic                      full_shown;
  logic [CntW+7:0]           count_ext;

  assign accept = start && !busy;

  assign lnk[0].tok   = accept;
  assign lnk[0].found = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [smt_pkg::ElemW-1:0] upper;
    if (i == CAPACITY - 1) begin : g_top
      assign upper = ent[i];
    end else begin : g_mid
      assign upper = ent[i+1];
    end
    smt_cell #(
      .IDX   (i),
      .CNT_W (CntW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .count      (count),
      .link_in    (lnk[i]),
      .next_entry (upper),
      .link_out   (lnk[i+1]),
      .entry      (ent[i])
    );
    assign tok_vec[i] = lnk[i+1].tok;
  end

  assign last  = lnk[CAPACITY].tok;
  assign found = lnk[CAPACITY].found;
  assign full  = (count == CntW'(CAPACITY));

  // Payload of the operation in flight.
  always_ff @(posedge clk) begin
    if (accept) begin
      op.func  <= func;
      op.value <= element;
    end
  end

  always_comb begin
    count_next  = count;
    status_next = smt_pkg::ST_MISS;
    case (op.func)
      smt_pkg::FUNC_ADD: begin
        if (found) begin
          status_next = smt_pkg::ST_MISS;
        end else if (full) begin
          status_next = smt_pkg::ST_FULL;
        end else begin
          status_next = smt_pkg::ST_OK;
          count_next  = count + CntW'(1);
        end
      end
      smt_pkg::FUNC_REMOVE: begin
        if (found) begin
          status_next = smt_pkg::ST_OK;
          count_next  = count - CntW'(1);
        end
      end
      default: begin
        status_next = found ? smt_pkg::ST_OK : smt_pkg::ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= last;
      if (accept) begin
        busy <= 1'b1;
      end else if (last) begin
        busy <= 1'b0;
      end
      if (last) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (last) begin
      status       <= status_next;
      element_echo <= op.value;
    end
  end

  assign count_ext   = {8'd0, count};
  assign entry_count = count_ext[7:0];

  assign full_shown = done && (status == smt_pkg::ST_FULL);

`include "set_membership_table_assert.svh"

  `SMT_ASSERT_ALWAYS(a_one_token, $onehot0(tok_vec), "more than one token in the chain")
  `SMT_ASSERT_ALWAYS(a_count_range, count <= CntW'(CAPACITY), "entry count above capacity")
  `SMT_ASSERT_NEXT(a_busy_after_accept, accept, busy, "busy low after a transfer")
  `SMT_ASSERT_IMPL(a_done_idle, done, !busy && !(|tok_vec), "result shown while a walk runs")
  `SMT_ASSERT_IMPL(a_full_status, full_shown, full, "full status with free entries")

endmodule

>>> tb/tb_set_membership_table.sv
// ---------------------------------------------------------------------------
// tb_set_membership_table
// Self-checking bench for the set membership table. A short table of
// directed operations covers the value extremes, every function code,
// duplicate adds and removes at the head, middle and tail of the store.
// Random traffic then cycles through mixed, fill and drain workloads so that
// the store reaches full capacity and empties again. Every result is checked
// field by field against a behavioral model of the set in the bench, or the table for typed rows.
// ---------------------------------------------------------------------------
module tb_set_membership_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SET_CAP = 128;
  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_OPS = 1080;
  localparam int MODE_SPAN = 180;
  localparam int WATCHDOG_LIMIT = 4000;
  // The spare function code behaves as a membership check.
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  typedef enum int { MIX_LOAD, FILL_LOAD, DRAIN_LOAD } load_t;

  typedef struct packed {
    logic [1:0]  st;
    logic [31:0] echo;
    logic [7:0]  cnt;
  } verdict_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] val;
    logic        typed;
    logic [1:0]  st;
    logic [7:0]  cnt;
  } probe_row_t;

  localparam int PROBE_ROWS = 22;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         func = smt_pkg::FUNC_CHECK;
  logic signed [31:0] element = '0;
  logic               done;
  logic [1:0]         status;
  logic signed [31:0] element_echo;
  logic [7:0]         entry_count;

  // Members of the set in store order, and results still to arrive.
  logic [31:0] held_values[$];
  verdict_t    pending_results[$];
  int          error_count = 0;
  int          stall_cycles = 0;

  probe_row_t probe_rows [PROBE_ROWS] = '{
    '{smt_pkg::FUNC_CHECK,  32'h0000_0000, 1'b1, smt_pkg::ST_MISS, 8'd0},
    '{smt_pkg::FUNC_REMOVE, 32'h8000_0000, 1'b1, smt_pkg::ST_MISS, 8'd0},
    '{smt_pkg::FUNC_ADD,    32'h8000_0000, 1'b1, smt_pkg::ST_OK,   8'd1},
    '{smt_pkg::FUNC_ADD,    32'h7FFF_FFFF, 1'b1, smt_pkg::ST_OK,   8'd2},
    '{smt_pkg::FUNC_ADD,    32'h0000_0000, 1'b1, smt_pkg::ST_OK,   8'd3},
    '{smt_pkg::FUNC_ADD,    32'hFFFF_FFFF, 1'b1, smt_pkg::ST_OK,   8'd4},
    '{smt_pkg::FUNC_ADD,    32'h7FFF_FFFF, 1'b1, smt_pkg::ST_MISS, 8'd4},
    '{smt_pkg::FUNC_CHECK,  32'h8000_0000, 1'b1, smt_pkg::ST_OK,   8'd4},
    '{FUNC_SPARE,           32'hFFFF_FFFF, 1'b1, smt_pkg::ST_OK,   8'd4},
    '{FUNC_SPARE,           32'h7FFF_FFFE, 1'b1, smt_pkg::ST_MISS, 8'd4},
    '{smt_pkg::FUNC_CHECK,  32'h0000_0001, 1'b1, smt_pkg::ST_MISS, 8'd4},
    '{smt_pkg::FUNC_REMOVE, 32'h7FFF_FFFF, 1'b1, smt_pkg::ST_OK,   8'd3},
    '{smt_pkg::FUNC_CHECK,  32'h7FFF_FFFF, 1'b1, smt_pkg::ST_MISS, 8'd3},
    '{smt_pkg::FUNC_CHECK,  32'h0000_0000, 1'b1, smt_pkg::ST_OK,   8'd3},
    '{smt_pkg::FUNC_REMOVE, 32'h8000_0000, 1'b1, smt_pkg::ST_OK,   8'd2},
    '{smt_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, 1'b1, smt_pkg::ST_OK,   8'd1},
    '{smt_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, 1'b1, smt_pkg::ST_MISS, 8'd1},
    '{smt_pkg::FUNC_ADD,    32'hFFFF_FFFE, 1'b0, smt_pkg::ST_OK,   8'd0},
    '{smt_pkg::FUNC_REMOVE, 32'h0000_0000, 1'b0, smt_pkg::ST_OK,   8'd0},
    '{smt_pkg::FUNC_ADD,    32'h5A5A_5A5A, 1'b0, smt_pkg::ST_OK,   8'd0},
    '{smt_pkg::FUNC_CHECK,  32'hFFFF_FFFE, 1'b0, smt_pkg::ST_OK,   8'd0},
    '{smt_pkg::FUNC_REMOVE, 32'hA5A5_A5A5, 1'b0, smt_pkg::ST_OK,   8'd0}
  };

  set_membership_table #(.CAPACITY(SET_CAP)) dut (.*);

  always #CLK_HALF clk = ~clk;

  // Applies one operation to the model of the set and returns its result.
  function automatic verdict_t apply_set_op(logic [1:0] op, logic [31:0] val);
    verdict_t v;
    int       slot;
    slot = -1;
    for (int i = 0; i < held_values.size(); i++) begin
      if (slot < 0 && held_values[i] == val) slot = i;
    end
    if (op == smt_pkg::FUNC_ADD) begin
      if (slot >= 0) v.st = smt_pkg::ST_MISS;
      else if (held_values.size() >= SET_CAP) v.st = smt_pkg::ST_FULL;
      else begin
        held_values.push_back(val);
        v.st = smt_pkg::ST_OK;
      end
    end else if (op == smt_pkg::FUNC_REMOVE) begin
      if (slot >= 0) begin
        held_values.delete(slot);
        v.st = smt_pkg::ST_OK;
      end else v.st = smt_pkg::ST_MISS;
    end else begin
      v.st = (slot >= 0) ? smt_pkg::ST_OK : smt_pkg::ST_MISS;
    end
    v.echo = val;
    v.cnt = 8'(held_values.size());
    return v;
  endfunction

  function automatic logic [31:0] pick_value(int member_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < member_pct && held_values.size() > 0)
      return held_values[$urandom_range(0, held_values.size() - 1)];
    if (roll < member_pct + 20) begin
      case ($urandom_range(0, 5))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        3: return 32'h7FFF_FFFF;
        4: return $urandom_range(0, 15);
        default: return 32'h1 << $urandom_range(0, 31);
      endcase
    end
    return $urandom();
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Holds start until the transfer, then records what the block must answer.
  task automatic issue_op(input logic [1:0] op, input logic [31:0] val,
                          input logic typed, input logic [1:0] st,
                          input logic [7:0] cnt);
    verdict_t v;
    start <= 1'b1;
    func <= op;
    element <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    v = apply_set_op(op, val);
    if (typed) begin
      v.st = st;
      v.cnt = cnt;
    end
    pending_results.push_back(v);
  endtask

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", element_echo, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st) flag_mismatch("status", 32'(status), 32'(want.st));
        if (element_echo !== want.echo) flag_mismatch("element_echo", element_echo, want.echo);
        if (entry_count !== want.cnt)
          flag_mismatch("entry_count", 32'(entry_count), 32'(want.cnt));
      end
    end
  end

  // Ends a run in which nothing has been transferred for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    load_t       load;
    int          idle_pct;
    int          roll;
    int          gap;
    logic [1:0]  op;
    logic [31:0] val;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (probe_rows[i]) begin
      issue_op(probe_rows[i].op, probe_rows[i].val, probe_rows[i].typed,
               probe_rows[i].st, probe_rows[i].cnt);
    end

    for (int n = 0; n < RANDOM_OPS; n++) begin
      case ((n * 3) / RANDOM_OPS)
        0: idle_pct = 13;
        1: idle_pct = 48;
        default: idle_pct = 0;
      endcase
      load = load_t'((n / MODE_SPAN) % 3);
      roll = $urandom_range(0, 99);
      case (load)
        FILL_LOAD: op = (roll < 90) ? smt_pkg::FUNC_ADD :
                        (roll < 93) ? smt_pkg::FUNC_REMOVE :
                        (roll < 98) ? smt_pkg::FUNC_CHECK : FUNC_SPARE;
        DRAIN_LOAD: op = (roll < 10) ? smt_pkg::FUNC_ADD :
                         (roll < 80) ? smt_pkg::FUNC_REMOVE :
                         (roll < 95) ? smt_pkg::FUNC_CHECK : FUNC_SPARE;
        default: op = (roll < 35) ? smt_pkg::FUNC_ADD :
                      (roll < 65) ? smt_pkg::FUNC_REMOVE :
                      (roll < 95) ? smt_pkg::FUNC_CHECK : FUNC_SPARE;
      endcase
      if (op == smt_pkg::FUNC_ADD) val = pick_value(load == FILL_LOAD ? 15 : 30);
      else if (op == smt_pkg::FUNC_REMOVE) val = pick_value(65);
      else val = pick_value(50);

      // Random idle gaps so that the next start can land on any cycle of a walk.
      gap = 0;
      if ($urandom_range(0, 99) < idle_pct)
        gap = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, 2 * SET_CAP + 2);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      issue_op(op, val, 1'b0, smt_pkg::ST_OK, 8'd0);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SET_CAP + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
